// ===== design/tpq_pkg.sv =====
// Shared types, constants and setup field helpers for the token priority queue mux.
`timescale 1ns / 1ps

package tpq_pkg;

	localparam int NUM_QUEUES = 4;
	localparam int FLOW_SLOTS = 256;

	localparam int QUEUE_W   = $clog2(NUM_QUEUES);
	localparam int SLOT_W    = $clog2(FLOW_SLOTS);
	localparam int SETUP_W   = 62;
	localparam int ECN_W     = 8;
	localparam int CREDIT_W  = 8;
	localparam int COUNT_W   = 16;
	localparam int TOKEN_W   = 20;
	localparam int LEN_W     = 16;
	localparam int RATE_W    = 8;
	localparam int PRIO_W    = 10;
	localparam int PROD_W    = RATE_W + LEN_W;
	localparam int CFG_IDX_W = 3;

	localparam logic [SETUP_W-1:0] SETUP_RESET = 62'h3E70FFFF01010064;
	localparam logic [ECN_W-1:0]   ECN_RESET   = 8'd10;
	localparam logic [PRIO_W-1:0]  PRIO_LIMIT  = 10'd999;

	localparam logic [CFG_IDX_W-1:0] CFG_QUEUE0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_ECN = 3'd4;

	localparam logic OP_ARRIVAL = 1'b0;
	localparam logic OP_DEQUEUE = 1'b1;

	typedef logic [SETUP_W-1:0] setup_t;
	typedef logic [NUM_QUEUES-1:0][SETUP_W-1:0] setup_vec_t;
	typedef logic [NUM_QUEUES-1:0][TOKEN_W-1:0] token_vec_t;
	typedef logic [NUM_QUEUES-1:0][COUNT_W-1:0] count_vec_t;
	typedef logic [NUM_QUEUES-1:0][PROD_W-1:0] prod_vec_t;
	typedef logic [NUM_QUEUES-1:0][NUM_QUEUES-1:0][PROD_W-1:0] gain_mat_t;
	typedef logic [NUM_QUEUES-1:0][PRIO_W-1:0] prio_vec_t;
	typedef logic [NUM_QUEUES-1:0][LEN_W-1:0] len_vec_t;

	typedef struct packed {
		logic               valid;
		logic [QUEUE_W-1:0] queue;
	} grant_t;

	typedef struct packed {
		logic               admitted;
		logic               mark_congestion;
		logic               grant_valid;
		logic [QUEUE_W-1:0] grant_queue;
	} result_t;

	function automatic logic [COUNT_W-1:0] f_thresh(setup_t s);
		return (s[15:0] == '0) ? COUNT_W'(1) : s[15:0];
	endfunction

	function automatic logic [RATE_W-1:0] f_refill(setup_t s);
		return (s[23:16] == '0) ? RATE_W'(1) : s[23:16];
	endfunction

	function automatic logic [RATE_W-1:0] f_spend(setup_t s);
		return (s[31:24] == '0) ? RATE_W'(1) : s[31:24];
	endfunction

	function automatic logic [TOKEN_W-1:0] f_cap(setup_t s);
		return (s[51:32] == '0) ? TOKEN_W'(1) : s[51:32];
	endfunction

	function automatic logic [PRIO_W-1:0] f_prio(setup_t s);
		return (s[61:52] == '0 || s[61:52] > PRIO_LIMIT) ? PRIO_LIMIT : s[61:52];
	endfunction

endpackage

// ===== design/tpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== design/tpq_pick.sv =====
// Dequeue arbiter over eligible queues: token-covered queues first, then lowest priority number, then lowest index.
`timescale 1ns / 1ps

module tpq_pick (
	input  logic [tpq_pkg::NUM_QUEUES-1:0] eligible,
	input  logic [tpq_pkg::NUM_QUEUES-1:0] covered,
	input  tpq_pkg::prio_vec_t             prio,
	output tpq_pkg::grant_t                grant
);

	always_comb begin
		logic                           found;
		logic                           best_ok;
		logic [tpq_pkg::PRIO_W-1:0]     best_prio;
		logic [tpq_pkg::QUEUE_W-1:0]    best;
		found     = 1'b0;
		best_ok   = 1'b0;
		best_prio = '0;
		best      = '0;
		for (int i = 0; i < tpq_pkg::NUM_QUEUES; i++) begin
			if (eligible[i]) begin
				if (!found || (covered[i] && !best_ok) ||
				    (covered[i] == best_ok && prio[i] < best_prio)) begin
					found     = 1'b1;
					best      = tpq_pkg::QUEUE_W'(i);
					best_ok   = covered[i];
					best_prio = prio[i];
				end
			end
		end
		grant.valid = found;
		grant.queue = best;
	end

endmodule

// ===== design/tpq_token.sv =====
// Token update after a grant: charge the winner, then refill every queue up to its cap.
`timescale 1ns / 1ps

module tpq_token (
	input  tpq_pkg::token_vec_t tokens,
	input  tpq_pkg::grant_t     grant,
	input  tpq_pkg::prod_vec_t  cost,
	input  tpq_pkg::gain_mat_t  gain,
	input  tpq_pkg::setup_vec_t setup,
	output tpq_pkg::token_vec_t tokens_next
);

	always_comb begin
		logic [tpq_pkg::TOKEN_W-1:0] base;
		logic [tpq_pkg::PROD_W:0]    sum;
		logic [tpq_pkg::TOKEN_W-1:0] cap;
		tokens_next = tokens;
		for (int i = 0; i < tpq_pkg::NUM_QUEUES; i++) begin
			base = tokens[i];
			if (grant.queue == tpq_pkg::QUEUE_W'(i)) begin
				if ({{(tpq_pkg::PROD_W - tpq_pkg::TOKEN_W){1'b0}}, tokens[i]} >= cost[i]) begin
					base = tokens[i] - cost[i][tpq_pkg::TOKEN_W-1:0];
				end else begin
					base = '0;
				end
			end
			sum = {{(tpq_pkg::PROD_W + 1 - tpq_pkg::TOKEN_W){1'b0}}, base}
			    + {1'b0, gain[i][grant.queue]};
			cap = tpq_pkg::f_cap(setup[i]);
			if (sum > {{(tpq_pkg::PROD_W + 1 - tpq_pkg::TOKEN_W){1'b0}}, cap}) begin
				tokens_next[i] = cap;
			end else begin
				tokens_next[i] = sum[tpq_pkg::TOKEN_W-1:0];
			end
		end
	end

endmodule

// ===== design/token_priority_queue_mux.sv =====
// Top level of the token priority queue mux: admission, congestion marking and dequeue arbitration.
`timescale 1ns / 1ps

// Takes one request per clock while req_stall is low and returns one result per request,
// in order. A request accepted at one rising edge is decided in the following cycle by
// combinational logic between the input stage and the result register, which captures
// its result for rsp_valid; the sustained rate is one request per cycle when nothing stalls,
// set by that stage reading and updating the per-queue counts and tokens in the same cycle.
// The result register decouples the two sides: a new request is accepted while a result
// waits, and req_stall rises only when a decided request and an untaken result are both
// held. Per-flow congestion credit sits in a RAM with one valid flag per flow slot,
// cleared at reset, so the block takes requests straight out of reset with no sweep.
// Configuration writes are taken every cycle (cfg_ready stays high) and must be issued
// only while no request is in flight.
module token_priority_queue_mux (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic                              operation,
	input  logic [tpq_pkg::QUEUE_W-1:0]       queue_index,
	input  logic [tpq_pkg::SLOT_W-1:0]        flow_slot,
	input  logic [tpq_pkg::LEN_W-1:0]         head_len_q0,
	input  logic [tpq_pkg::LEN_W-1:0]         head_len_q1,
	input  logic [tpq_pkg::LEN_W-1:0]         head_len_q2,
	input  logic [tpq_pkg::LEN_W-1:0]         head_len_q3,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic                              admitted,
	output logic                              mark_congestion,
	output logic                              grant_valid,
	output logic [tpq_pkg::QUEUE_W-1:0]       grant_queue,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tpq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tpq_pkg::SETUP_W-1:0]       cfg_data
);

	tpq_pkg::setup_vec_t                setup_q;
	logic [tpq_pkg::ECN_W-1:0]          max_ecn_q;
	tpq_pkg::count_vec_t                count_q;
	tpq_pkg::count_vec_t                count_d;
	tpq_pkg::token_vec_t                token_q;
	tpq_pkg::token_vec_t                token_d;
	tpq_pkg::token_vec_t                token_next;
	logic [tpq_pkg::FLOW_SLOTS-1:0]     credit_vld_q;

	logic                               valid_s1;
	logic                               op_s1;
	logic [tpq_pkg::QUEUE_W-1:0]        queue_s1;
	logic [tpq_pkg::SLOT_W-1:0]         slot_s1;
	tpq_pkg::prod_vec_t                 cost_s1;
	tpq_pkg::gain_mat_t                 gain_s1;
	logic                               vld_s1;
	logic                               byp_s1;
	logic [tpq_pkg::CREDIT_W-1:0]       byp_data_s1;

	logic                               rsp_valid_q;
	tpq_pkg::result_t                   rsp_q;

	tpq_pkg::len_vec_t                  len_in;
	tpq_pkg::prod_vec_t                 cost_d;
	tpq_pkg::gain_mat_t                 gain_d;
	logic                               accept;
	logic                               advance;
	logic [tpq_pkg::CREDIT_W-1:0]       ram_rdata;
	logic [tpq_pkg::CREDIT_W-1:0]       credit_cur;
	logic [tpq_pkg::CREDIT_W-1:0]       credit_new;
	logic                               credit_we;
	logic [tpq_pkg::NUM_QUEUES-1:0]     eligible;
	logic [tpq_pkg::NUM_QUEUES-1:0]     covered;
	tpq_pkg::prio_vec_t                 prio;
	tpq_pkg::grant_t                    grant;
	tpq_pkg::result_t                   res;

	assign len_in    = {head_len_q3, head_len_q2, head_len_q1, head_len_q0};
	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && rsp_valid_q && rsp_stall;
	assign accept    = req_valid && !req_stall;
	assign cfg_ready = 1'b1;

	assign rsp_valid       = rsp_valid_q;
	assign admitted        = rsp_q.admitted;
	assign mark_congestion = rsp_q.mark_congestion;
	assign grant_valid     = rsp_q.grant_valid;
	assign grant_queue     = rsp_q.grant_queue;

	// Precompute charge and refill products per head length.
	always_comb begin
		for (int i = 0; i < tpq_pkg::NUM_QUEUES; i++) begin
			cost_d[i] = tpq_pkg::PROD_W'(tpq_pkg::f_spend(setup_q[i]))
			          * tpq_pkg::PROD_W'(len_in[i]);
			for (int j = 0; j < tpq_pkg::NUM_QUEUES; j++) begin
				gain_d[i][j] = tpq_pkg::PROD_W'(tpq_pkg::f_refill(setup_q[i]))
				             * tpq_pkg::PROD_W'(len_in[j]);
			end
		end
	end

	tpq_ram #(
		.WIDTH(tpq_pkg::CREDIT_W),
		.DEPTH(tpq_pkg::FLOW_SLOTS)
	) u_credit_ram (
		.clk  (clk),
		.we   (credit_we),
		.waddr(slot_s1),
		.wdata(credit_new),
		.re   (accept),
		.raddr(flow_slot),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= operation;
			queue_s1    <= queue_index;
			slot_s1     <= flow_slot;
			cost_s1     <= cost_d;
			gain_s1     <= gain_d;
			vld_s1      <= credit_vld_q[flow_slot];
			byp_s1      <= credit_we && (slot_s1 == flow_slot);
			byp_data_s1 <= credit_new;
		end
	end

	assign credit_cur = byp_s1 ? byp_data_s1 : (vld_s1 ? ram_rdata : '0);

	always_comb begin
		for (int i = 0; i < tpq_pkg::NUM_QUEUES; i++) begin
			eligible[i] = (count_q[i] != '0);
			covered[i]  = ({{(tpq_pkg::PROD_W - tpq_pkg::TOKEN_W){1'b0}}, token_q[i]}
			              >= cost_s1[i]);
			prio[i]     = tpq_pkg::f_prio(setup_q[i]);
		end
	end

	tpq_pick u_pick (
		.eligible(eligible),
		.covered (covered),
		.prio    (prio),
		.grant   (grant)
	);

	tpq_token u_token (
		.tokens     (token_q),
		.grant      (grant),
		.cost       (cost_s1),
		.gain       (gain_s1),
		.setup      (setup_q),
		.tokens_next(token_next)
	);

	always_comb begin
		count_d    = count_q;
		token_d    = token_q;
		credit_new = credit_cur;
		credit_we  = 1'b0;
		res        = '0;
		if (op_s1 == tpq_pkg::OP_ARRIVAL) begin
			credit_we = advance;
			if (count_q[queue_s1] < tpq_pkg::f_thresh(setup_q[queue_s1])) begin
				res.admitted      = 1'b1;
				count_d[queue_s1] = count_q[queue_s1] + tpq_pkg::COUNT_W'(1);
				if (credit_cur != '0) begin
					res.mark_congestion = 1'b1;
					credit_new          = credit_cur - tpq_pkg::CREDIT_W'(1);
				end
			end else if (credit_cur < max_ecn_q) begin
				credit_new = credit_cur + tpq_pkg::CREDIT_W'(1);
			end
		end else if (grant.valid) begin
			count_d[grant.queue] = count_q[grant.queue] - tpq_pkg::COUNT_W'(1);
			token_d              = token_next;
			res.grant_valid      = 1'b1;
			res.grant_queue      = grant.queue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			token_q      <= '0;
			credit_vld_q <= '0;
		end else if (advance) begin
			count_q <= count_d;
			token_q <= token_d;
			if (credit_we) begin
				credit_vld_q[slot_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tpq_pkg::NUM_QUEUES; i++) begin
				setup_q[i] <= tpq_pkg::SETUP_RESET;
			end
			max_ecn_q <= tpq_pkg::ECN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index < tpq_pkg::CFG_MAX_ECN) begin
				setup_q[cfg_index[tpq_pkg::QUEUE_W-1:0] - tpq_pkg::CFG_QUEUE0[tpq_pkg::QUEUE_W-1:0]]
					<= cfg_data;
			end else if (cfg_index == tpq_pkg::CFG_MAX_ECN) begin
				max_ecn_q <= cfg_data[tpq_pkg::ECN_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= res;
		end
	end

endmodule

// ===== design/tpq_checker.sv =====
// Port-level checker for the token priority queue mux, bound to the top level.
`timescale 1ns / 1ps

module tpq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input logic                          admitted,
	input logic                          mark_congestion,
	input logic                          grant_valid,
	input logic [tpq_pkg::QUEUE_W-1:0]   grant_queue
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(admitted) &&
		$stable(mark_congestion) && $stable(grant_valid) && $stable(grant_queue))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> rsp_valid && rsp_stall)
		else $error("request stalled with no waiting result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> ##1 rsp_valid)
		else $error("accepted request produced no result");

	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(grant_valid && (admitted || mark_congestion)) &&
		!(mark_congestion && !admitted))
		else $error("inconsistent result fields");

endmodule

bind token_priority_queue_mux tpq_checker u_tpq_checker (.*);

// ===== tb/sv/token_priority_queue_mux_test.sv =====
// Self-checking testbench for the token priority queue mux with a built-in predictor.
`timescale 1ns / 1ps

module token_priority_queue_mux_test;

	import tpq_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 10;
	localparam int IDLE_PCT     = 19;
	localparam int THRESH_LSB   = 0;
	localparam int REFILL_LSB   = 16;
	localparam int SPEND_LSB    = 24;
	localparam int CAP_LSB      = 32;
	localparam int PRIO_LSB     = 52;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_FIRST = CFG_MAX_ECN + 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LAST  = '1;

	typedef struct packed {
		logic               op;
		logic [QUEUE_W-1:0] queue;
		logic [SLOT_W-1:0]  slot;
		len_vec_t           len;
	} req_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 req_valid = 1'b0;
	logic                 req_stall;
	logic                 operation = OP_ARRIVAL;
	logic [QUEUE_W-1:0]   queue_index = '0;
	logic [SLOT_W-1:0]    flow_slot = '0;
	logic [LEN_W-1:0]     head_len_q0 = '0;
	logic [LEN_W-1:0]     head_len_q1 = '0;
	logic [LEN_W-1:0]     head_len_q2 = '0;
	logic [LEN_W-1:0]     head_len_q3 = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	logic                 admitted;
	logic                 mark_congestion;
	logic                 grant_valid;
	logic [QUEUE_W-1:0]   grant_queue;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [SETUP_W-1:0]   cfg_data = '0;

	req_item_t queued_requests[$];
	result_t   predicted_outcomes[$];
	req_item_t offered_req;

	setup_t             q_setup[NUM_QUEUES];
	logic [ECN_W-1:0]   ecn_limit;
	logic [COUNT_W-1:0] q_count[NUM_QUEUES];
	logic [TOKEN_W-1:0] q_tokens[NUM_QUEUES];
	logic [CREDIT_W-1:0] flow_credit[FLOW_SLOTS];

	int send_idle_pct = IDLE_PCT;
	int rsp_idle_pct = IDLE_PCT;
	logic hold_kick = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int failures = 0;
	int cycle_count = 0;

	token_priority_queue_mux i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_stall       (req_stall),
		.operation       (operation),
		.queue_index     (queue_index),
		.flow_slot       (flow_slot),
		.head_len_q0     (head_len_q0),
		.head_len_q1     (head_len_q1),
		.head_len_q2     (head_len_q2),
		.head_len_q3     (head_len_q3),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.admitted        (admitted),
		.mark_congestion (mark_congestion),
		.grant_valid     (grant_valid),
		.grant_queue     (grant_queue),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	always #5ns clk = ~clk;

	function automatic int unsigned field_or_one(setup_t s, int lsb, int w);
		longint unsigned v;
		v = 64'(s >> lsb) & ((64'd1 << w) - 64'd1);
		return (v == 0) ? 1 : int'(v);
	endfunction

	function automatic int unsigned queue_rank(setup_t s);
		int unsigned p;
		p = 32'(s[PRIO_LSB +: PRIO_W]);
		return (p == 0 || p > PRIO_LIMIT) ? 32'(PRIO_LIMIT) : p;
	endfunction

	function automatic void reset_model();
		for (int i = 0; i < NUM_QUEUES; i++) begin
			q_setup[i] = SETUP_RESET;
			q_count[i] = '0;
			q_tokens[i] = '0;
		end
		for (int i = 0; i < FLOW_SLOTS; i++) begin
			flow_credit[i] = '0;
		end
		ecn_limit = ECN_RESET;
	endfunction

	function automatic result_t decide_request(req_item_t r);
		result_t res;
		int unsigned qi, sl, best, best_rank, rank_i;
		longint unsigned cost, level, win_len, cap_v;
		bit found, best_ok, ok;
		res = '0;
		found = 1'b0;
		best_ok = 1'b0;
		best = 0;
		best_rank = 0;
		if (r.op == OP_ARRIVAL) begin
			qi = 32'(r.queue);
			sl = 32'(r.slot);
			if (q_count[qi] < field_or_one(q_setup[qi], THRESH_LSB, COUNT_W)) begin
				q_count[qi] = q_count[qi] + 1'b1;
				res.admitted = 1'b1;
				if (flow_credit[sl] != 0) begin
					res.mark_congestion = 1'b1;
					flow_credit[sl] = flow_credit[sl] - 1'b1;
				end
			end else if (flow_credit[sl] < ecn_limit) begin
				flow_credit[sl] = flow_credit[sl] + 1'b1;
			end
		end else begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				if (q_count[i] != 0) begin
					cost = 64'(field_or_one(q_setup[i], SPEND_LSB, RATE_W)) * 64'(r.len[i]);
					ok = (64'(q_tokens[i]) >= cost);
					rank_i = queue_rank(q_setup[i]);
					if (!found || (ok && !best_ok)
							|| (ok == best_ok && rank_i < best_rank)) begin
						found = 1'b1;
						best = 32'(i);
						best_ok = ok;
						best_rank = rank_i;
					end
				end
			end
			if (found) begin
				win_len = 64'(r.len[best]);
				cost = 64'(field_or_one(q_setup[best], SPEND_LSB, RATE_W)) * win_len;
				q_count[best] = q_count[best] - 1'b1;
				level = 64'(q_tokens[best]);
				q_tokens[best] = (level >= cost) ? TOKEN_W'(level - cost) : '0;
				for (int i = 0; i < NUM_QUEUES; i++) begin
					level = 64'(q_tokens[i])
						+ 64'(field_or_one(q_setup[i], REFILL_LSB, RATE_W)) * win_len;
					cap_v = 64'(field_or_one(q_setup[i], CAP_LSB, TOKEN_W));
					q_tokens[i] = TOKEN_W'((level > cap_v) ? cap_v : level);
				end
				res.grant_valid = 1'b1;
				res.grant_queue = QUEUE_W'(best);
			end
		end
		return res;
	endfunction

	function automatic setup_t pack_setup(int unsigned thr, int unsigned rf, int unsigned sp,
			int unsigned cap, int unsigned pr);
		return {PRIO_W'(pr), TOKEN_W'(cap), RATE_W'(sp), RATE_W'(rf), COUNT_W'(thr)};
	endfunction

	function automatic setup_t random_setup(bit tight);
		int unsigned thr, cap;
		if (tight) begin
			thr = $urandom_range(4);
		end else begin
			thr = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(40, 1);
		end
		cap = ($urandom_range(3) == 0) ? $urandom_range(16) : $urandom_range(20'hFFFFF);
		return pack_setup(thr, $urandom_range(255), $urandom_range(255), cap,
			$urandom_range(1023));
	endfunction

	function automatic setup_t random_wide();
		return SETUP_W'({$urandom, $urandom});
	endfunction

	function automatic req_item_t rand_request(int arr_pct, int span);
		req_item_t r;
		int mode;
		r.op = ($urandom_range(99) < arr_pct) ? OP_ARRIVAL : OP_DEQUEUE;
		r.queue = QUEUE_W'($urandom_range(NUM_QUEUES - 1));
		r.slot = SLOT_W'((span >= FLOW_SLOTS) ? $urandom_range(FLOW_SLOTS - 1)
			: $urandom_range(span - 1));
		mode = $urandom_range(3);
		for (int q = 0; q < NUM_QUEUES; q++) begin
			case (mode)
				0: r.len[q] = LEN_W'($urandom_range(63));
				1: r.len[q] = LEN_W'($urandom_range(65535));
				2: r.len[q] = $urandom_range(1) ? '1 : '0;
				default: r.len[q] = LEN_W'($urandom_range(1023));
			endcase
		end
		return r;
	endfunction

	task automatic push_req(logic op, int q, int sl, int l0, int l1, int l2, int l3);
		req_item_t r;
		r.op = op;
		r.queue = QUEUE_W'(q);
		r.slot = SLOT_W'(sl);
		r.len = {LEN_W'(l3), LEN_W'(l2), LEN_W'(l1), LEN_W'(l0)};
		queued_requests.push_back(r);
	endtask

	// sample away from the rising edge so the driver and monitor have settled
	task automatic wait_drained();
		do @(negedge clk);
		while (queued_requests.size() != 0 || req_valid || predicted_outcomes.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_random(int n, int arr_pct, int span);
		repeat (n) queued_requests.push_back(rand_request(arr_pct, span));
		wait_drained();
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, setup_t data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx < CFG_MAX_ECN) begin
			q_setup[idx[QUEUE_W-1:0] - CFG_QUEUE0[QUEUE_W-1:0]] = data;
		end else if (idx == CFG_MAX_ECN) begin
			ecn_limit = data[ECN_W-1:0];
		end
	endtask

	task automatic write_queue(int q, setup_t data);
		write_reg(CFG_QUEUE0 + CFG_IDX_W'(q), data);
	endtask

	task automatic write_ecn(int unsigned limit);
		write_reg(CFG_MAX_ECN, SETUP_W'({random_wide(), ECN_W'(limit)}));
	endtask

	// hold a stalled request, advance only on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				predicted_outcomes.push_back(decide_request(offered_req));
			end
			if (!req_valid || !req_stall) begin
				if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					offered_req = queued_requests.pop_front();
					req_valid <= 1'b1;
					operation <= offered_req.op;
					queue_index <= offered_req.queue;
					flow_slot <= offered_req.slot;
					head_len_q0 <= offered_req.len[0];
					head_len_q1 <= offered_req.len[1];
					head_len_q2 <= offered_req.len[2];
					head_len_q3 <= offered_req.len[3];
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				got = '{admitted, mark_congestion, grant_valid, grant_queue};
				if (predicted_outcomes.size() == 0) begin
					failures++;
					if (failures <= MAX_REPORTS) begin
						$display("unexpected response: adm %b mark %b grant %b q %0d",
							got.admitted, got.mark_congestion, got.grant_valid,
							got.grant_queue);
					end
				end else begin
					want = predicted_outcomes.pop_front();
					if (got.admitted !== want.admitted
							|| got.mark_congestion !== want.mark_congestion
							|| got.grant_valid !== want.grant_valid
							|| got.grant_queue !== want.grant_queue) begin
						failures++;
						if (failures <= MAX_REPORTS) begin
							$display("mismatch at %0t: expected adm %b mark %b grant %b q %0d",
								$realtime, want.admitted, want.mark_congestion,
								want.grant_valid, want.grant_queue);
							$display("  got adm %b mark %b grant %b q %0d",
								got.admitted, got.mark_congestion, got.grant_valid,
								got.grant_queue);
						end
					end
				end
			end
			if (hold_kick && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("token_priority_queue_mux_test NOT OK");
			$finish;
		end
	end

	initial begin
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		push_req(OP_DEQUEUE, 0, 0, 65535, 65535, 65535, 65535);
		push_req(OP_ARRIVAL, 0, 0, 0, 0, 0, 0);
		push_req(OP_ARRIVAL, 1, 255, 65535, 65535, 65535, 65535);
		push_req(OP_ARRIVAL, 2, 8'hAA, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
		push_req(OP_ARRIVAL, 3, 8'h55, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		push_req(OP_DEQUEUE, 0, 0, 0, 0, 0, 0);
		push_req(OP_DEQUEUE, 3, 255, 65535, 65535, 65535, 65535);
		push_req(OP_DEQUEUE, 0, 0, 1, 2, 3, 4);
		push_req(OP_DEQUEUE, 0, 0, 65535, 65535, 65535, 65535);
		push_req(OP_DEQUEUE, 0, 0, 7, 7, 7, 7);
		wait_drained();
		run_random(250, 60, FLOW_SLOTS);

		// shallow queues and a high credit limit: drops build credit, later arrivals get marked
		for (int q = 0; q < NUM_QUEUES; q++) write_queue(q, random_setup(1'b1));
		write_queue(0, pack_setup(1, 3, 2, 500, 5));
		write_ecn(255);
		push_req(OP_ARRIVAL, 0, 7, 0, 0, 0, 0);
		push_req(OP_ARRIVAL, 0, 7, 0, 0, 0, 0);
		push_req(OP_ARRIVAL, 0, 7, 0, 0, 0, 0);
		push_req(OP_DEQUEUE, 0, 0, 0, 0, 0, 0);
		push_req(OP_ARRIVAL, 0, 7, 0, 0, 0, 0);
		wait_drained();
		run_random(300, 65, 8);

		// zero fields act as one, out-of-range priorities act as the limit
		write_queue(0, '0);
		write_queue(1, pack_setup(2, 0, 0, 0, 0));
		write_queue(2, pack_setup(3, 7, 9, 1000, 1023));
		write_queue(3, pack_setup(5, 1, 1, 50, 1000));
		write_ecn(0);
		push_req(OP_ARRIVAL, 0, 3, 9, 9, 9, 9);
		push_req(OP_ARRIVAL, 0, 3, 9, 9, 9, 9);
		push_req(OP_DEQUEUE, 0, 0, 2, 2, 2, 2);
		wait_drained();
		run_random(250, 60, 16);

		for (int q = 0; q < NUM_QUEUES; q++) write_queue(q, '1);
		write_reg(CFG_MAX_ECN, '1);
		write_reg(CFG_SPARE_FIRST, random_wide());
		write_reg(CFG_SPARE_LAST, random_wide());
		run_random(200, 55, 4);

		// build tokens under a wide cap, then lower the cap
		for (int q = 0; q < NUM_QUEUES; q++) begin
			write_queue(q, pack_setup(8, 255, 1, 20'hFFFFF, $urandom_range(1023)));
		end
		write_ecn($urandom_range(255));
		run_random(150, 50, FLOW_SLOTS);
		for (int q = 0; q < NUM_QUEUES; q++) begin
			write_queue(q, pack_setup(8, 255, 1, $urandom_range(12, 3), $urandom_range(1023)));
		end
		run_random(150, 50, FLOW_SLOTS);

		for (int q = 0; q < NUM_QUEUES; q++) write_queue(q, random_setup(1'b1));
		write_ecn($urandom_range(255));
		send_idle_pct <= 0;
		rsp_idle_pct <= 0;
		run_random(250, 60, 32);
		send_idle_pct <= IDLE_PCT;
		rsp_idle_pct <= IDLE_PCT;

		// receiver holds off while the sender keeps offering
		@(posedge clk);
		send_idle_pct <= 0;
		hold_kick <= 1'b1;
		run_random(200, 60, 32);
		send_idle_pct <= IDLE_PCT;

		repeat (3) begin
			for (int q = 0; q < NUM_QUEUES; q++) begin
				write_queue(q, random_setup(1'($urandom_range(1))));
			end
			write_ecn($urandom_range(255));
			run_random(80, 55, 64);
			run_random(80, 55, 64);
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (failures == 0 && predicted_outcomes.size() == 0) begin
			$display("token_priority_queue_mux_test OK");
		end else begin
			$display("token_priority_queue_mux_test NOT OK");
		end
		$finish;
	end

endmodule
